// ===== hdl/zsr_pkg.sv =====
// ----------------------------------------------------------------------------
// zsr_pkg
// Shared types and constants of the z-axis slice resampler.
// ----------------------------------------------------------------------------
package zsr_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int MaxSlices   = 1024;
  localparam int FracBits    = 16;
  localparam int MaxOut      = 16;
  localparam int PixW        = 16;
  localparam int XyW         = 8;
  localparam int SliceW      = 10;
  localparam int DimW        = 9;
  localparam int CountW      = 11;
  localparam int NumW        = 37;
  localparam int DenW        = 10;
  localparam int PosW        = 38;
  localparam int AddrW       = 16;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 11;

  localparam logic [CfgIdxW-1:0] REG_SLICE_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLICE_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLICES_IN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLICES_OUT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTERP_MODE  = 3'd4;

  localparam logic DIV_STEP = 1'b0;
  localparam logic DIV_BASE = 1'b1;

  typedef struct packed {
    logic load;
    logic iter_step;
    logic finish;
    logic emit_adv;
    logic div_start;
    logic div_sel;
    logic clear_stale;
  } cmd_t;

  typedef struct packed {
    logic stale;
    logic div_done;
    logic hit;
    logic cnt_zero;
    logic emit_last;
  } sts_t;

endpackage

// ===== hdl/zsr_ifs.sv =====
// ----------------------------------------------------------------------------
// zsr channel interfaces
// Valid/ready channels for input voxels and resampled result voxels.
// ----------------------------------------------------------------------------
interface zsr_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        volume_start;
  modport source (output valid, pixel_value, volume_start, input ready);
  modport sink (input valid, pixel_value, volume_start, output ready);
endinterface

interface zsr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [9:0]  out_slice;
  logic [15:0] out_value;
  logic        dropped;
  logic        last;
  modport source (output valid, out_x, out_y, out_slice, out_value, dropped, last,
                  input ready);
  modport sink (input valid, out_x, out_y, out_slice, out_value, dropped, last,
                output ready);
endinterface

// ===== hdl/zsr_div.sv =====
// ----------------------------------------------------------------------------
// zsr_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zsr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [zsr_pkg::NumW-1:0]  num,
  input  logic [zsr_pkg::DenW-1:0]  den,
  output logic                      done,
  output logic [zsr_pkg::NumW-1:0]  quo,
  output logic [zsr_pkg::DenW-1:0]  rem
);

  logic                     busy;
  logic [5:0]               cnt;
  logic [zsr_pkg::DenW:0]   sh;
  logic                     ge;
  logic [zsr_pkg::DenW:0]   diff;

  assign sh   = {rem, quo[zsr_pkg::NumW-1]};
  assign ge   = sh >= {1'b0, den};
  assign diff = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(zsr_pkg::NumW - 1);
        quo  <= num;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[zsr_pkg::DenW-1:0] : sh[zsr_pkg::DenW-1:0];
        quo <= {quo[zsr_pkg::NumW-2:0], ge};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/zsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// zsr_ctrl
// Sequencer: step setup, buffer read, slice walk, result emission, commit.
// ----------------------------------------------------------------------------
module zsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  zsr_pkg::sts_t sts,
  output zsr_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sts.stale) begin
          // a write landing during the setup marks it stale again
          cmd.div_start   = 1'b1;
          cmd.div_sel     = zsr_pkg::DIV_STEP;
          cmd.clear_stale = 1'b1;
          state_next      = S_DIV1;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = zsr_pkg::DIV_BASE;
          state_next    = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_ITER;
      end
      S_ITER: begin
        if (sts.hit) begin
          cmd.iter_step = 1'b1;
        end else if (sts.cnt_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.emit_last) begin
            state_next = S_DONE;
          end else begin
            cmd.emit_adv = 1'b1;
          end
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/zsr_dp.sv =====
// ----------------------------------------------------------------------------
// zsr_dp
// Datapath: configuration, counters, slice buffer, position walk, results.
// ----------------------------------------------------------------------------
module zsr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [zsr_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [zsr_pkg::CfgDataW-1:0]  wr_data,
  input  logic [zsr_pkg::PixW-1:0]      pixel_value,
  input  logic                          volume_start,
  output logic [zsr_pkg::XyW-1:0]       out_x,
  output logic [zsr_pkg::XyW-1:0]       out_y,
  output logic [zsr_pkg::SliceW-1:0]    out_slice,
  output logic [zsr_pkg::PixW-1:0]      out_value,
  output logic                          dropped,
  output logic                          last,
  input  zsr_pkg::cmd_t                 cmd,
  output zsr_pkg::sts_t                 sts
);

  localparam int PW = zsr_pkg::PosW;
  localparam int FB = zsr_pkg::FracBits;
  localparam int EW = zsr_pkg::SliceW + zsr_pkg::PixW;

  // configuration
  logic [zsr_pkg::DimW-1:0]   slice_width, slice_height;
  logic [zsr_pkg::CountW-1:0] slices_in, slices_out;
  logic                       interp_mode;
  logic                       stale;

  logic [zsr_pkg::DimW-1:0]   w_c, h_c;
  logic [zsr_pkg::CountW-1:0] sin_c, sout_c;
  logic [zsr_pkg::DenW-1:0]   sin_m1, den;

  always_comb begin
    w_c    = (slice_width == '0) ? 9'd1 :
             (slice_width > 9'(zsr_pkg::MaxWidth)) ? 9'(zsr_pkg::MaxWidth) : slice_width;
    h_c    = (slice_height == '0) ? 9'd1 :
             (slice_height > 9'(zsr_pkg::MaxHeight)) ? 9'(zsr_pkg::MaxHeight) : slice_height;
    sin_c  = (slices_in == '0) ? 11'd1 :
             (slices_in > 11'(zsr_pkg::MaxSlices)) ? 11'(zsr_pkg::MaxSlices) : slices_in;
    sout_c = (slices_out == '0) ? 11'd1 :
             (slices_out > 11'(zsr_pkg::MaxSlices)) ? 11'(zsr_pkg::MaxSlices) : slices_out;
    sin_m1 = zsr_pkg::DenW'(sin_c - 11'd1);
    den    = (sout_c > 11'd1) ? zsr_pkg::DenW'(sout_c - 11'd1) : 10'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width  <= 9'd256;
      slice_height <= 9'd256;
      slices_in    <= 11'd1;
      slices_out   <= 11'd1;
      interp_mode  <= 1'b1;
      stale        <= 1'b1;
    end else begin
      if (wr_en) begin
        stale <= 1'b1;
        unique case (wr_index)
          zsr_pkg::REG_SLICE_WIDTH:  slice_width  <= wr_data[zsr_pkg::DimW-1:0];
          zsr_pkg::REG_SLICE_HEIGHT: slice_height <= wr_data[zsr_pkg::DimW-1:0];
          zsr_pkg::REG_SLICES_IN:    slices_in    <= wr_data;
          zsr_pkg::REG_SLICES_OUT:   slices_out   <= wr_data;
          zsr_pkg::REG_INTERP_MODE:  interp_mode  <= wr_data[0];
          default: ;
        endcase
      end else if (cmd.clear_stale) begin
        stale <= 1'b0;
      end
    end
  end

  // counters and per-slice position base
  logic [zsr_pkg::XyW-1:0]    x_count, y_count;
  logic [zsr_pkg::SliceW-1:0] input_slice;
  logic [zsr_pkg::CountW-1:0] first_out_slice;
  logic [PW-1:0]              base_p;
  logic [zsr_pkg::DenW-1:0]   base_r;

  // divider setup: step between output slices and position of first slice
  logic [PW-2:0]              step_q;
  logic [zsr_pkg::DenW-1:0]   step_r;
  logic [20:0]                base_prod;
  logic                       div_sel;
  logic [zsr_pkg::NumW-1:0]   div_num, div_quo;
  logic [zsr_pkg::DenW-1:0]   div_rem;
  logic                       div_done;

  assign div_num = cmd.div_sel ? {base_prod, 16'd0} : {11'd0, sin_m1, 16'd0};

  zsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    base_prod <= first_out_slice * sin_m1;
    if (cmd.div_start) begin
      div_sel <= cmd.div_sel;
    end
  end

  // per-item working registers
  logic [zsr_pkg::PixW-1:0]   pix, prev;
  logic [zsr_pkg::AddrW-1:0]  addr;
  logic [zsr_pkg::CountW-1:0] cur_z, count;
  logic [PW-1:0]              pos;
  logic [zsr_pkg::DenW-1:0]   pos_r;
  logic [3:0]                 emit_idx;
  logic [EW-1:0]              res_buf [zsr_pkg::MaxOut];
  logic [zsr_pkg::PixW-1:0]   mem [zsr_pkg::MaxWidth*zsr_pkg::MaxHeight];

  // load-time values, volume start clears the counters
  logic [zsr_pkg::XyW-1:0]    x_eff, y_eff;
  logic [zsr_pkg::AddrW-1:0]  addr_eff;

  always_comb begin
    x_eff    = (volume_start || {1'b0, x_count} >= w_c) ? '0 : x_count;
    y_eff    = (volume_start || {1'b0, y_count} >= h_c) ? '0 : y_count;
    addr_eff = {x_eff, y_eff};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prev <= mem[addr_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mem[addr] <= pix;
    end
  end

  // slice walk
  logic [PW-FB:0]           ceil_src;
  logic [FB-1:0]            frac;
  logic                     hit;
  logic [zsr_pkg::PixW-1:0] lo, val;
  logic signed [17:0]       diff;
  logic signed [35:0]       prod, acc;
  logic [zsr_pkg::DenW:0]   r_sum, r_wrap;
  logic                     r_ge;

  always_comb begin
    frac     = pos[FB-1:0];
    ceil_src = {1'b0, pos[PW-1:FB]} + (PW-FB+1)'(frac != '0);
    hit      = (cur_z < sout_c) && (ceil_src <= (PW-FB+1)'(input_slice));
    lo       = (frac != '0) ? prev : pix;
    diff     = $signed({2'b00, pix}) - $signed({2'b00, lo});
    prod     = diff * $signed({2'b00, frac});
    acc      = $signed({4'd0, lo, 16'd0}) + prod + 36'sd32768;
    if (interp_mode) begin
      val = acc[31:16];
    end else begin
      // nearest rounds half up: current slice unless frac is below one half
      val = (frac == '0 || frac[FB-1]) ? pix : prev;
    end
    r_sum  = {1'b0, pos_r} + {1'b0, step_r};
    r_ge   = r_sum >= {1'b0, den};
    r_wrap = r_sum - {1'b0, den};
  end

  logic [zsr_pkg::CountW-1:0] n_res;
  assign n_res = (count > 11'(zsr_pkg::MaxOut)) ? 11'(zsr_pkg::MaxOut) : count;

  // commit arithmetic
  logic [zsr_pkg::DimW-1:0]   y_inc, x_inc;
  logic [zsr_pkg::CountW:0]   slice_inc;
  logic [zsr_pkg::CountW:0]   first_sum;

  always_comb begin
    y_inc     = {1'b0, y_count} + 9'd1;
    x_inc     = {1'b0, x_count} + 9'd1;
    slice_inc = {2'b00, input_slice} + 12'd1;
    first_sum = {1'b0, first_out_slice} + {1'b0, count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count         <= '0;
      y_count         <= '0;
      input_slice     <= '0;
      first_out_slice <= '0;
      base_p          <= '0;
      base_r          <= '0;
      count           <= '0;
      emit_idx        <= '0;
    end else begin
      if (div_done) begin
        if (div_sel == zsr_pkg::DIV_STEP) begin
          step_q <= div_quo;
          step_r <= div_rem;
        end else begin
          base_p <= {1'b0, div_quo};
          base_r <= div_rem;
        end
      end
      if (cmd.load) begin
        pix      <= pixel_value;
        x_count  <= x_eff;
        y_count  <= y_eff;
        addr     <= addr_eff;
        count    <= '0;
        emit_idx <= '0;
        if (volume_start) begin
          input_slice     <= '0;
          first_out_slice <= '0;
          base_p          <= '0;
          base_r          <= '0;
          cur_z           <= '0;
          pos             <= '0;
          pos_r           <= '0;
        end else begin
          cur_z <= first_out_slice;
          pos   <= base_p;
          pos_r <= base_r;
        end
      end
      if (cmd.iter_step) begin
        if (count < 11'(zsr_pkg::MaxOut)) begin
          res_buf[count[3:0]] <= {cur_z[zsr_pkg::SliceW-1:0], val};
        end
        count <= count + 11'd1;
        cur_z <= cur_z + 11'd1;
        pos   <= pos + {1'b0, step_q} + PW'(r_ge);
        pos_r <= r_ge ? r_wrap[zsr_pkg::DenW-1:0] : r_sum[zsr_pkg::DenW-1:0];
      end
      if (cmd.emit_adv) begin
        emit_idx <= emit_idx + 4'd1;
      end
      if (cmd.finish) begin
        if (y_inc >= h_c) begin
          y_count <= '0;
          if (x_inc >= w_c) begin
            x_count <= '0;
            if (slice_inc >= {1'b0, sin_c} || slice_inc > 12'd1023) begin
              input_slice     <= '0;
              first_out_slice <= '0;
              base_p          <= '0;
              base_r          <= '0;
            end else begin
              input_slice     <= slice_inc[zsr_pkg::SliceW-1:0];
              first_out_slice <= (first_sum > 12'd2047) ? 11'd2047 : first_sum[10:0];
              // walk stopped exactly at the next first output slice
              base_p          <= pos;
              base_r          <= pos_r;
            end
          end else begin
            x_count <= x_inc[zsr_pkg::XyW-1:0];
          end
        end else begin
          y_count <= y_inc[zsr_pkg::XyW-1:0];
        end
      end
    end
  end

  assign out_x     = x_count;
  assign out_y     = y_count;
  assign out_slice = res_buf[emit_idx][EW-1:zsr_pkg::PixW];
  assign out_value = res_buf[emit_idx][zsr_pkg::PixW-1:0];
  assign dropped   = count > 11'(zsr_pkg::MaxOut);
  assign last      = ({7'd0, emit_idx} + 11'd1) == n_res;

  always_comb begin
    sts           = '0;
    sts.stale     = stale;
    sts.div_done  = div_done;
    sts.hit       = hit;
    sts.cnt_zero  = count == '0;
    sts.emit_last = last;
  end

endmodule

// ===== hdl/z_axis_slice_resampler_top.sv =====
// One input voxel is taken per transaction; the block then reads the buffered
// voxel of the previous slice, walks the candidate output slices one per
// cycle, and streams up to 16 results one per cycle while the output is ready.
// After any configuration write, the next item waits while the serial divider
// sets up the slice step and the current position base.
// ----------------------------------------------------------------------------
// z_axis_slice_resampler_top
// Z-axis slice resampler, nearest or linear, with a one-slice buffer.
// ----------------------------------------------------------------------------
module z_axis_slice_resampler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [zsr_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [zsr_pkg::CfgDataW-1:0] wr_data,
  zsr_in_if.sink                       item,
  zsr_out_if.source                    result
);

  zsr_pkg::cmd_t cmd;
  zsr_pkg::sts_t sts;

  zsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  zsr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .pixel_value  (item.pixel_value),
    .volume_start (item.volume_start),
    .out_x        (result.out_x),
    .out_y        (result.out_y),
    .out_slice    (result.out_slice),
    .out_value    (result.out_value),
    .dropped      (result.dropped),
    .last         (result.last),
    .cmd          (cmd),
    .sts          (sts)
  );

  // one item in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    !(item.ready && result.valid))
    else $error("input ready while results pending");

  assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second transaction accepted back to back");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && result.last |=> !result.valid)
    else $error("result after last");

endmodule
